/* design/coupling_graph_distance_matrix_unit_assert.svh */
// assertion macros for the coupling graph distance matrix unit
// each macro expects signals named clk and rst in the scope where it is used
`ifndef COUPLING_GRAPH_DISTANCE_MATRIX_UNIT_ASSERT_SVH
`define COUPLING_GRAPH_DISTANCE_MATRIX_UNIT_ASSERT_SVH

// same-cycle implication
`define CGDM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cgdm assertion failed");

// next-cycle implication
`define CGDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cgdm assertion failed");

`endif

/* design/cgdm_pkg.sv */
// ----------------------------------------------------------------------------
// cgdm_pkg
// Types, constants and helper functions shared by the distance matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cgdm_pkg;

  localparam int MAX_SITES = 8;
  localparam int VERTEX_W  = 3;
  localparam int COUNT_W   = 4;
  localparam int DIST_W    = 4;
  localparam int DEGREE_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  localparam logic [DIST_W-1:0] UNREACHABLE = DIST_W'(MAX_SITES);

  localparam logic [CFG_IDX_W-1:0] REG_NUM_SITES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPLICIT  = 1'd1;

  typedef enum logic [1:0] {
    STATUS_OK             = 2'd0,
    STATUS_UNKNOWN_VERTEX = 2'd1,
    STATUS_SELF_COUPLING  = 2'd2,
    STATUS_DISCONNECTED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DECIDE,
    ST_ROW_INIT,
    ST_BFS_STEP,
    ST_EMIT_READ,
    ST_EMIT,
    ST_ERROR_OUT
  } state_t;

  typedef logic [MAX_SITES-1:0] site_vec_t;

  typedef struct packed {
    logic load_edge;
    logic run_start;
    logic row_init;
    logic bfs_level;
    logic row_store;
    logic row_next;
    logic row_zero;
    logic col_next;
    logic col_zero;
    logic push_dist;
    logic push_err;
    logic clear_run;
  } cmd_t;

  typedef struct packed {
    logic err_pending;
    logic explicit_mode;
    logic frontier_empty;
    logic row_last;
    logic col_last;
    logic out_free;
  } stat_t;

  // bits 0 .. n-1 set
  function automatic site_vec_t site_mask(input logic [COUNT_W-1:0] n);
    site_vec_t m;
    for (int i = 0; i < MAX_SITES; i++) begin
      m[i] = (COUNT_W'(i) < n);
    end
    return m;
  endfunction

  function automatic logic [COUNT_W-1:0] pop_count(input site_vec_t v);
    logic [COUNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < MAX_SITES; i++) begin
      c = c + COUNT_W'(v[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/cgdm_ctrl.sv */
// ----------------------------------------------------------------------------
// cgdm_ctrl
// Sequencer for edge loading, per-row breadth-first search and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module cgdm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            last_edge,
  output logic                 in_ready,
  input  wire cgdm_pkg::stat_t stat,
  output cgdm_pkg::cmd_t       cmd
);

  cgdm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgdm_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      cgdm_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_edge = 1'b1;
          if (last_edge) begin
            state_next = cgdm_pkg::ST_DECIDE;
          end
        end
      end
      cgdm_pkg::ST_DECIDE: begin
        if (stat.err_pending) begin
          state_next = cgdm_pkg::ST_ERROR_OUT;
        end else begin
          cmd.run_start = 1'b1;
          state_next = stat.explicit_mode ? cgdm_pkg::ST_ROW_INIT : cgdm_pkg::ST_EMIT_READ;
        end
      end
      cgdm_pkg::ST_ROW_INIT: begin
        cmd.row_init = 1'b1;
        state_next   = cgdm_pkg::ST_BFS_STEP;
      end
      cgdm_pkg::ST_BFS_STEP: begin
        if (stat.frontier_empty) begin
          cmd.row_store = 1'b1;
          if (stat.row_last) begin
            cmd.row_zero = 1'b1;
            state_next   = cgdm_pkg::ST_EMIT_READ;
          end else begin
            cmd.row_next = 1'b1;
            state_next   = cgdm_pkg::ST_ROW_INIT;
          end
        end else begin
          cmd.bfs_level = 1'b1;
        end
      end
      cgdm_pkg::ST_EMIT_READ: begin
        // memory row read lands at the end of this cycle
        state_next = cgdm_pkg::ST_EMIT;
      end
      cgdm_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.push_dist = 1'b1;
          if (stat.col_last) begin
            cmd.col_zero = 1'b1;
            if (stat.row_last) begin
              cmd.clear_run = 1'b1;
              state_next    = cgdm_pkg::ST_LOAD;
            end else begin
              cmd.row_next = 1'b1;
              state_next   = cgdm_pkg::ST_EMIT_READ;
            end
          end else begin
            cmd.col_next = 1'b1;
          end
        end
      end
      cgdm_pkg::ST_ERROR_OUT: begin
        if (stat.out_free) begin
          cmd.push_err  = 1'b1;
          cmd.clear_run = 1'b1;
          state_next    = cgdm_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = cgdm_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/cgdm_datapath.sv */
// ----------------------------------------------------------------------------
// cgdm_datapath
// Adjacency bitmap, search registers, distance memory and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cgdm_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [cgdm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [cgdm_pkg::CFG_DAT_W-1:0]         cfg_data,
  input  wire logic [cgdm_pkg::VERTEX_W-1:0]          source_vertex,
  input  wire logic [cgdm_pkg::VERTEX_W-1:0]          target_vertex,
  input  wire logic                                   edge_valid,
  input  wire cgdm_pkg::cmd_t                         cmd,
  output cgdm_pkg::stat_t                             stat,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [cgdm_pkg::VERTEX_W-1:0]               row_vertex,
  output logic [cgdm_pkg::VERTEX_W-1:0]               column_vertex,
  output logic [cgdm_pkg::DIST_W-1:0]                 hop_distance,
  output logic [cgdm_pkg::DEGREE_W-1:0]               max_vertex_degree,
  output logic [1:0]                                  status_code,
  output logic                                        last_result
);

  typedef logic [cgdm_pkg::MAX_SITES-1:0][cgdm_pkg::DIST_W-1:0] dist_row_t;

  logic [cgdm_pkg::COUNT_W-1:0]  num_sites;
  logic                          explicit_topology;
  cgdm_pkg::site_vec_t           adjacency_rows [cgdm_pkg::MAX_SITES];
  cgdm_pkg::status_t             sticky_error;
  cgdm_pkg::site_vec_t           visited_mask;
  cgdm_pkg::site_vec_t           frontier_mask;
  dist_row_t                     dist_row;
  dist_row_t                     distance_store [cgdm_pkg::MAX_SITES];
  dist_row_t                     rd_row;
  logic [cgdm_pkg::DIST_W-1:0]   level;
  logic [cgdm_pkg::VERTEX_W-1:0] row_cnt;
  logic [cgdm_pkg::VERTEX_W-1:0] col_cnt;
  logic [cgdm_pkg::DEGREE_W-1:0] degree;
  cgdm_pkg::status_t             run_status;

  logic [cgdm_pkg::COUNT_W-1:0]  n_eff;
  logic [cgdm_pkg::COUNT_W-1:0]  last_idx;
  cgdm_pkg::site_vec_t           nmask;
  cgdm_pkg::site_vec_t           next_front;
  logic [cgdm_pkg::COUNT_W-1:0]  row_pop;
  logic                          bad_vertex;
  logic [cgdm_pkg::DIST_W-1:0]   dist_sel;
  logic [cgdm_pkg::DEGREE_W-1:0] degree_sel;

  // out-of-range counts are clamped to 1 .. MAX_SITES
  always_comb begin
    priority if (num_sites == '0) begin
      n_eff = cgdm_pkg::COUNT_W'(1);
    end else if (num_sites > cgdm_pkg::COUNT_W'(cgdm_pkg::MAX_SITES)) begin
      n_eff = cgdm_pkg::COUNT_W'(cgdm_pkg::MAX_SITES);
    end else begin
      n_eff = num_sites;
    end
  end

  assign last_idx = n_eff - cgdm_pkg::COUNT_W'(1);
  assign nmask    = cgdm_pkg::site_mask(n_eff);
  assign row_pop  = cgdm_pkg::pop_count(adjacency_rows[row_cnt] & nmask);

  assign bad_vertex = ({1'b0, source_vertex} >= n_eff) || ({1'b0, target_vertex} >= n_eff);

  // one search level: neighbours of the whole frontier, not yet visited
  always_comb begin
    next_front = '0;
    for (int v = 0; v < cgdm_pkg::MAX_SITES; v++) begin
      if (frontier_mask[v]) begin
        next_front = next_front | adjacency_rows[v];
      end
    end
    next_front = next_front & nmask & ~visited_mask;
  end

  assign stat.err_pending    = (sticky_error != cgdm_pkg::STATUS_OK);
  assign stat.explicit_mode  = explicit_topology;
  assign stat.frontier_empty = (frontier_mask == '0);
  assign stat.row_last       = (row_cnt == last_idx[cgdm_pkg::VERTEX_W-1:0]);
  assign stat.col_last       = (col_cnt == last_idx[cgdm_pkg::VERTEX_W-1:0]);
  assign stat.out_free       = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_sites         <= cgdm_pkg::COUNT_W'(cgdm_pkg::MAX_SITES);
      explicit_topology <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cgdm_pkg::REG_NUM_SITES: num_sites         <= cfg_data;
        cgdm_pkg::REG_EXPLICIT:  explicit_topology <= cfg_data[0];
      endcase
    end
  end

  // adjacency bitmap and first error of the run
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_run) begin
      for (int i = 0; i < cgdm_pkg::MAX_SITES; i++) begin
        adjacency_rows[i] <= '0;
      end
      sticky_error <= cgdm_pkg::STATUS_OK;
    end else if (cmd.load_edge && edge_valid) begin
      if (bad_vertex) begin
        if (sticky_error == cgdm_pkg::STATUS_OK) begin
          sticky_error <= cgdm_pkg::STATUS_UNKNOWN_VERTEX;
        end
      end else if (source_vertex == target_vertex) begin
        if (sticky_error == cgdm_pkg::STATUS_OK) begin
          sticky_error <= cgdm_pkg::STATUS_SELF_COUPLING;
        end
      end else begin
        adjacency_rows[source_vertex][target_vertex] <= 1'b1;
        adjacency_rows[target_vertex][source_vertex] <= 1'b1;
      end
    end
  end

  // search registers for the current row
  always_ff @(posedge clk) begin
    if (cmd.row_init) begin
      visited_mask  <= cgdm_pkg::site_vec_t'(1) << row_cnt;
      frontier_mask <= cgdm_pkg::site_vec_t'(1) << row_cnt;
      level         <= '0;
      for (int i = 0; i < cgdm_pkg::MAX_SITES; i++) begin
        dist_row[i] <= (cgdm_pkg::VERTEX_W'(i) == row_cnt) ? '0 : cgdm_pkg::UNREACHABLE;
      end
    end else if (cmd.bfs_level) begin
      visited_mask  <= visited_mask | next_front;
      frontier_mask <= next_front;
      level         <= level + cgdm_pkg::DIST_W'(1);
      for (int i = 0; i < cgdm_pkg::MAX_SITES; i++) begin
        if (next_front[i]) begin
          dist_row[i] <= level + cgdm_pkg::DIST_W'(1);
        end
      end
    end
  end

  // run summary: degree and connectivity
  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      degree     <= '0;
      run_status <= cgdm_pkg::STATUS_OK;
    end else begin
      if (cmd.row_init && (row_pop > {1'b0, degree})) begin
        degree <= row_pop[cgdm_pkg::DEGREE_W-1:0];
      end
      if (cmd.row_store && (visited_mask != nmask)) begin
        run_status <= cgdm_pkg::STATUS_DISCONNECTED;
      end
    end
  end

  // row and column counters
  always_ff @(posedge clk) begin
    if (cmd.run_start || cmd.row_zero) begin
      row_cnt <= '0;
    end else if (cmd.row_next) begin
      row_cnt <= row_cnt + cgdm_pkg::VERTEX_W'(1);
    end
    if (cmd.run_start || cmd.col_zero) begin
      col_cnt <= '0;
    end else if (cmd.col_next) begin
      col_cnt <= col_cnt + cgdm_pkg::VERTEX_W'(1);
    end
  end

  // distance memory, one row per entry
  always_ff @(posedge clk) begin
    if (cmd.row_store) begin
      distance_store[row_cnt] <= dist_row;
    end
    rd_row <= distance_store[row_cnt];
  end

  assign dist_sel = explicit_topology ? rd_row[col_cnt] :
                    ((row_cnt == col_cnt) ? '0 : cgdm_pkg::DIST_W'(1));
  assign degree_sel = explicit_topology ? degree : last_idx[cgdm_pkg::DEGREE_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_dist || cmd.push_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_err) begin
      row_vertex        <= '0;
      column_vertex     <= '0;
      hop_distance      <= '0;
      max_vertex_degree <= '0;
      status_code       <= sticky_error;
      last_result       <= 1'b1;
    end else if (cmd.push_dist) begin
      row_vertex        <= row_cnt;
      column_vertex     <= col_cnt;
      hop_distance      <= dist_sel;
      max_vertex_degree <= degree_sel;
      status_code       <= run_status;
      last_result       <= stat.row_last && stat.col_last;
    end
  end

endmodule

`default_nettype wire

/* design/coupling_graph_distance_matrix_unit.sv */
// ----------------------------------------------------------------------------
// coupling_graph_distance_matrix_unit
// All-pairs hop distances of a coupling graph: repeated BFS, else complete.
// ----------------------------------------------------------------------------
// Usage: edges arrive as requests on the input channel (in_valid/in_ready),
// one per cycle while the unit is loading. A request with last_edge set ends
// the load; in_ready then stays low until the final result has been handed
// to the output register. Results leave on out_valid/out_ready, row by row,
// n*n of them, n the clamped num_sites, the last flagged by last_result.
// A run with a bad edge yields one error result instead.
// Sequence after the last request, n the clamped vertex count:
//   a decision step; explicit topology adds per row a row initialisation
//   and the search, doing one frontier level per cycle
//   emission per row: a memory row read, then n results, one a cycle while
//   the output register is free; error run: one error result
// A stalled receiver holds the output register and the sequencer waits on it.
// Reset (rst, synchronous) restores num_sites to 8, explicit topology on,
// clears the adjacency bitmap and error, and empties the output register.
// Configuration writes (cfg_we) take effect on the next cycle.
`default_nettype none

module coupling_graph_distance_matrix_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [cgdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cgdm_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [cgdm_pkg::VERTEX_W-1:0]  source_vertex,
  input  wire logic [cgdm_pkg::VERTEX_W-1:0]  target_vertex,
  input  wire logic                           edge_valid,
  input  wire logic                           last_edge,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [cgdm_pkg::VERTEX_W-1:0]       row_vertex,
  output logic [cgdm_pkg::VERTEX_W-1:0]       column_vertex,
  output logic [cgdm_pkg::DIST_W-1:0]         hop_distance,
  output logic [cgdm_pkg::DEGREE_W-1:0]       max_vertex_degree,
  output logic [1:0]                          status_code,
  output logic                                last_result
);

  cgdm_pkg::cmd_t  cmd;
  cgdm_pkg::stat_t stat;

  cgdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_edge (last_edge),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cgdm_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .source_vertex     (source_vertex),
    .target_vertex     (target_vertex),
    .edge_valid        (edge_valid),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .row_vertex        (row_vertex),
    .column_vertex     (column_vertex),
    .hop_distance      (hop_distance),
    .max_vertex_degree (max_vertex_degree),
    .status_code       (status_code),
    .last_result       (last_result)
  );

endmodule

`default_nettype wire

/* design/cgdm_checker.sv */
// ----------------------------------------------------------------------------
// cgdm_checker
// Port-level checks on the result channel of the distance matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coupling_graph_distance_matrix_unit_assert.svh"

module cgdm_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [cgdm_pkg::VERTEX_W-1:0] row_vertex,
  input wire logic [cgdm_pkg::VERTEX_W-1:0] column_vertex,
  input wire logic [cgdm_pkg::DIST_W-1:0]   hop_distance,
  input wire logic [cgdm_pkg::DEGREE_W-1:0] max_vertex_degree,
  input wire logic [1:0]                    status_code,
  input wire logic                          last_result
);

  logic err_result;
  logic out_stall;
  logic zero_fields;
  logic diag_entry;
  logic [2*cgdm_pkg::VERTEX_W+cgdm_pkg::DIST_W+cgdm_pkg::DEGREE_W+2:0] held_fields;

  assign err_result = out_valid &&
                      ((status_code == cgdm_pkg::STATUS_UNKNOWN_VERTEX) ||
                       (status_code == cgdm_pkg::STATUS_SELF_COUPLING));

  assign out_stall   = out_valid && !out_ready;
  assign held_fields = {row_vertex, column_vertex, hop_distance, max_vertex_degree,
                        status_code, last_result};
  assign zero_fields = (row_vertex == '0) && (column_vertex == '0) &&
                       (hop_distance == '0) && (max_vertex_degree == '0);
  assign diag_entry  = out_valid && !err_result && (row_vertex == column_vertex);

  // stalled result holds
  `CGDM_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(held_fields))

  // an error run is a single zeroed result
  `CGDM_ASSERT_NOW(a_err_single, err_result, last_result && zero_fields)

  // diagonal entries of a matrix are zero hops
  `CGDM_ASSERT_NOW(a_diag_zero, diag_entry, hop_distance == '0)

  // distances never exceed the unreachable mark
  `CGDM_ASSERT_NOW(a_dist_range, out_valid, hop_distance <= cgdm_pkg::UNREACHABLE)

endmodule

bind coupling_graph_distance_matrix_unit cgdm_checker u_cgdm_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .row_vertex        (row_vertex),
  .column_vertex     (column_vertex),
  .hop_distance      (hop_distance),
  .max_vertex_degree (max_vertex_degree),
  .status_code       (status_code),
  .last_result       (last_result)
);

`default_nettype wire

/* tb/tb_coupling_graph_distance_matrix_unit.sv */
// ----------------------------------------------------------------------------
// tb_coupling_graph_distance_matrix_unit
// Loads coupling edges and checks every hop distance the unit emits.
// A scoreboard class keeps its own adjacency and error state and a BFS
// predictor. It queues the expected distance matrix (or the error result)
// when a request closes a run. Results are then checked in order, field by
// field. Directed runs come first, then random graphs under random settings,
// with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------

module tb_coupling_graph_distance_matrix_unit;
  import cgdm_pkg::*;

  localparam int RANDOM_REQUESTS = 200;
  localparam int SETTLE_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT  = 2000;

  class distance_scoreboard;
    typedef struct {
      logic [VERTEX_W-1:0] row;
      logic [VERTEX_W-1:0] col;
      logic [DIST_W-1:0]   hop;
      logic [DEGREE_W-1:0] degree;
      status_t             status;
      logic                last;
    } entry_t;

    logic [COUNT_W-1:0] num_sites;
    logic               explicit_topology;
    site_vec_t          adjacency [MAX_SITES];
    status_t            run_error;
    entry_t             expected_entries [$];
    int                 fail_count;

    function new();
      num_sites         = COUNT_W'(MAX_SITES);
      explicit_topology = 1'b1;
      fail_count        = 0;
      clear_run();
    endfunction

    function void clear_run();
      for (int v = 0; v < MAX_SITES; v++) adjacency[v] = '0;
      run_error = STATUS_OK;
    endfunction

    // 0 acts as 1, anything above the maximum as the maximum
    function int active_sites();
      if (num_sites == 0) return 1;
      if (num_sites > MAX_SITES) return MAX_SITES;
      return int'(num_sites);
    endfunction

    function int pending();
      return expected_entries.size();
    endfunction

    function void write_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DAT_W-1:0] data);
      if (idx == REG_NUM_SITES) num_sites = data;
      else if (idx == REG_EXPLICIT) explicit_topology = data[0];
    endfunction

    function void accept_edge_request(input logic [VERTEX_W-1:0] src,
                                      input logic [VERTEX_W-1:0] dst,
                                      input logic has_edge, input logic is_last);
      int        n;
      int        degree;
      int        level;
      int        hops [MAX_SITES][MAX_SITES];
      site_vec_t in_use;
      site_vec_t seen;
      site_vec_t frontier;
      site_vec_t reach;
      status_t   run_status;
      entry_t    e;
      n      = active_sites();
      in_use = site_vec_t'((1 << n) - 1);
      if (has_edge) begin
        // only the first error of a run is kept
        if (src >= n || dst >= n) begin
          if (run_error == STATUS_OK) run_error = STATUS_UNKNOWN_VERTEX;
        end else if (src == dst) begin
          if (run_error == STATUS_OK) run_error = STATUS_SELF_COUPLING;
        end else begin
          adjacency[src][dst] = 1'b1;
          adjacency[dst][src] = 1'b1;
        end
      end
      if (!is_last) return;
      if (run_error != STATUS_OK) begin
        e.row    = '0;
        e.col    = '0;
        e.hop    = '0;
        e.degree = '0;
        e.status = run_error;
        e.last   = 1'b1;
        expected_entries.push_back(e);
        clear_run();
        return;
      end
      run_status = STATUS_OK;
      if (!explicit_topology) begin
        degree = n - 1;
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++) hops[r][c] = (r == c) ? 0 : 1;
      end else begin
        degree = 0;
        for (int v = 0; v < n; v++)
          if ($countones(adjacency[v] & in_use) > degree)
            degree = $countones(adjacency[v] & in_use);
        for (int r = 0; r < n; r++) begin
          for (int c = 0; c < n; c++) hops[r][c] = MAX_SITES;
          hops[r][r] = 0;
          seen       = site_vec_t'(1) << r;
          frontier   = seen;
          level      = 0;
          // one frontier level per pass
          while (frontier != '0) begin
            reach = '0;
            for (int v = 0; v < n; v++)
              if (frontier[v]) reach = reach | adjacency[v];
            reach = reach & in_use & ~seen;
            level++;
            for (int v = 0; v < n; v++)
              if (reach[v]) hops[r][v] = level;
            seen     = seen | reach;
            frontier = reach;
          end
          if (seen != in_use) run_status = STATUS_DISCONNECTED;
        end
      end
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) begin
          e.row    = VERTEX_W'(r);
          e.col    = VERTEX_W'(c);
          e.hop    = DIST_W'(hops[r][c]);
          e.degree = DEGREE_W'(degree);
          e.status = run_status;
          e.last   = (r == n - 1) && (c == n - 1);
          expected_entries.push_back(e);
        end
      clear_run();
    endfunction

    task report(input string what);
      fail_count++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_distance_result(input logic [VERTEX_W-1:0] row,
                               input logic [VERTEX_W-1:0] col,
                               input logic [DIST_W-1:0] hop,
                               input logic [DEGREE_W-1:0] degree,
                               input logic [1:0] status, input logic last);
      entry_t e;
      if (expected_entries.size() == 0) begin
        report($sformatf("unexpected result row %0d col %0d hop %0d", row, col, hop));
        return;
      end
      e = expected_entries.pop_front();
      if (row !== e.row)
        report($sformatf("row_vertex %0d, wanted %0d", row, e.row));
      if (col !== e.col)
        report($sformatf("column_vertex %0d, wanted %0d", col, e.col));
      if (hop !== e.hop)
        report($sformatf("hop_distance %0d, wanted %0d (row %0d col %0d)",
                         hop, e.hop, e.row, e.col));
      if (degree !== e.degree)
        report($sformatf("max_vertex_degree %0d, wanted %0d", degree, e.degree));
      if (status !== e.status)
        report($sformatf("status_code %0d, wanted %0d", status, e.status));
      if (last !== e.last)
        report($sformatf("last_result %0b, wanted %0b", last, e.last));
    endtask

    task report_leftovers();
      if (expected_entries.size() != 0)
        report($sformatf("%0d results never arrived", expected_entries.size()));
    endtask
  endclass

  typedef struct {
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] dst;
    logic                has_edge;
    logic                is_last;
  } request_t;

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_DAT_W-1:0] cfg_data      = '0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic [VERTEX_W-1:0]  source_vertex = '0;
  logic [VERTEX_W-1:0]  target_vertex = '0;
  logic                 edge_valid    = 1'b0;
  logic                 last_edge     = 1'b0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [VERTEX_W-1:0]  row_vertex;
  logic [VERTEX_W-1:0]  column_vertex;
  logic [DIST_W-1:0]    hop_distance;
  logic [DEGREE_W-1:0]  max_vertex_degree;
  logic [1:0]           status_code;
  logic                 last_result;

  distance_scoreboard sb;
  request_t           run_q [$];
  int                 counted_requests = 0;
  int                 burst_left       = 0;
  int                 stuck_cycles     = 0;
  int                 ready_mode       = 0;
  int                 ready_hold       = 0;
  int                 ready_phase      = 0;

  coupling_graph_distance_matrix_unit u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .source_vertex     (source_vertex),
    .target_vertex     (target_vertex),
    .edge_valid        (edge_valid),
    .last_edge         (last_edge),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .row_vertex        (row_vertex),
    .column_vertex     (column_vertex),
    .hop_distance      (hop_distance),
    .max_vertex_degree (max_vertex_degree),
    .status_code       (status_code),
    .last_result       (last_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // handshakes are sampled at the edge, before any update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.accept_edge_request(source_vertex, target_vertex, edge_valid, last_edge);
      if (out_valid && out_ready)
        sb.check_distance_result(row_vertex, column_vertex, hop_distance,
                                 max_vertex_degree, status_code, last_result);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver: modes of steady, random, sparse and periodic stalls
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_hold = $urandom_range(8, 60);
    end else begin
      ready_hold--;
    end
    ready_phase++;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (ready_phase % 7) > 2;
    endcase
  end

  task automatic send_request(input logic [VERTEX_W-1:0] src,
                              input logic [VERTEX_W-1:0] dst,
                              input logic has_edge, input logic is_last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    source_vertex <= src;
    target_vertex <= dst;
    edge_valid    <= has_edge;
    last_edge     <= is_last;
    do @(posedge clk); while (!in_ready);
    counted_requests++;
  endtask

  // hold requests back until the last result is in, then let the unit settle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_register(idx, data);
    @(posedge clk);
  endtask

  task automatic queue_edge(input int a, input int b);
    request_t rq;
    if ($urandom_range(0, 9) == 0) begin
      rq.src      = VERTEX_W'($urandom_range(0, 7));
      rq.dst      = VERTEX_W'($urandom_range(0, 7));
      rq.has_edge = 1'b0;
      rq.is_last  = 1'b0;
      run_q.push_back(rq);
    end
    rq.has_edge = 1'b1;
    rq.is_last  = 1'b0;
    if ($urandom_range(0, 1) == 1) begin
      rq.src = VERTEX_W'(a);
      rq.dst = VERTEX_W'(b);
    end else begin
      rq.src = VERTEX_W'(b);
      rq.dst = VERTEX_W'(a);
    end
    run_q.push_back(rq);
    // duplicate, given as b to a
    if ($urandom_range(0, 6) == 0) begin
      rq.src = VERTEX_W'(b);
      rq.dst = VERTEX_W'(a);
      run_q.push_back(rq);
    end
  endtask

  task automatic queue_random_edge(input int n);
    int a;
    int b;
    a = $urandom_range(0, n - 1);
    b = $urandom_range(0, n - 2);
    if (b >= a) b++;
    queue_edge(a, b);
  endtask

  task automatic build_random_run();
    int       n;
    int       kind;
    int       j;
    int       tmp;
    int       order [MAX_SITES];
    request_t rq;
    run_q.delete();
    n    = sb.active_sites();
    kind = $urandom_range(0, 9);
    if (kind <= 5 && n >= 2) begin
      // random spanning tree, then a few chords
      for (int i = 0; i < n; i++) order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 1; i < n; i++) queue_edge(order[i], order[$urandom_range(0, i - 1)]);
      repeat ($urandom_range(0, 4)) queue_random_edge(n);
    end else if (kind <= 7 && n >= 2) begin
      repeat ($urandom_range(0, n)) queue_random_edge(n);
    end else if (kind == 8) begin
      if (n >= 2) repeat ($urandom_range(0, 3)) queue_random_edge(n);
      rq.has_edge = 1'b1;
      rq.is_last  = 1'b0;
      if (n < MAX_SITES && $urandom_range(0, 1) == 1) begin
        rq.src = VERTEX_W'($urandom_range(n, 7));
        rq.dst = VERTEX_W'($urandom_range(0, 7));
        if ($urandom_range(0, 1) == 1) begin
          tmp    = rq.src;
          rq.src = rq.dst;
          rq.dst = VERTEX_W'(tmp);
        end
      end else begin
        rq.src = VERTEX_W'($urandom_range(0, n - 1));
        rq.dst = rq.src;
      end
      run_q.insert($urandom_range(0, run_q.size()), rq);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        rq.src      = VERTEX_W'($urandom_range(0, 7));
        rq.dst      = VERTEX_W'($urandom_range(0, 7));
        rq.has_edge = 1'($urandom_range(0, 1));
        rq.is_last  = 1'b0;
        run_q.push_back(rq);
      end
    end
    // the run closes on its final queued request or on an added empty request
    if (run_q.size() == 0 || $urandom_range(0, 3) == 0) begin
      rq.src      = VERTEX_W'($urandom_range(0, 7));
      rq.dst      = VERTEX_W'($urandom_range(0, 7));
      rq.has_edge = 1'b0;
      rq.is_last  = 1'b1;
      run_q.push_back(rq);
    end else begin
      run_q[run_q.size() - 1].is_last = 1'b1;
    end
  endtask

  task automatic random_settings();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) pick = $urandom_range(2, 8);
    else if (pick == 7) pick = 1;
    else if (pick == 8) pick = 0;
    else pick = $urandom_range(9, 15);
    drain_and_settle();
    write_register(REG_NUM_SITES, CFG_DAT_W'(pick));
    write_register(REG_EXPLICIT,
                   {3'($urandom_range(0, 7)), 1'($urandom_range(0, 3) != 0)});
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // chain with a reversed and a duplicate edge, eight sites
    send_request(0, 1, 1, 0);
    send_request(2, 1, 1, 0);
    send_request(2, 3, 1, 0);
    send_request(3, 4, 1, 0);
    send_request(5, 4, 1, 0);
    send_request(5, 6, 1, 0);
    send_request(7, 6, 1, 0);
    send_request(1, 0, 1, 1);
    // single edge carried by the closing request, rest disconnected
    send_request(0, 7, 1, 1);
    // self coupling, then an empty closing request
    send_request(3, 3, 1, 0);
    send_request(4, 5, 1, 0);
    send_request(7, 7, 0, 1);

    drain_and_settle();
    write_register(REG_NUM_SITES, 4'd4);
    // unknown vertex wins over the later self coupling
    send_request(5, 1, 1, 0);
    send_request(2, 2, 1, 0);
    send_request(0, 3, 1, 1);
    // star around site 0
    send_request(0, 1, 1, 0);
    send_request(0, 2, 1, 0);
    send_request(3, 0, 1, 1);

    drain_and_settle();
    write_register(REG_EXPLICIT, 4'd0);
    write_register(REG_NUM_SITES, 4'd0);
    send_request(0, 0, 0, 1);

    drain_and_settle();
    write_register(REG_NUM_SITES, 4'd15);
    // complete graph ignores edges but still checks them
    send_request(2, 5, 1, 1);
    send_request(6, 6, 1, 1);

    drain_and_settle();
    write_register(REG_EXPLICIT, 4'd1);
    write_register(REG_NUM_SITES, 4'd1);
    send_request(0, 0, 0, 1);
    send_request(1, 0, 1, 1);
    send_request(0, 0, 1, 1);

    counted_requests = 0;
    while (counted_requests < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 3) == 0) random_settings();
      else if ($urandom_range(0, 7) == 0) drain_and_settle();
      build_random_run();
      foreach (run_q[i])
        send_request(run_q[i].src, run_q[i].dst, run_q[i].has_edge, run_q[i].is_last);
    end

    drain_and_settle();
    sb.report_leftovers();
    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
